// ===== hdl/sfs_pkg.sv =====
// ----------------------------------------------------------------------------
// sfs_pkg: shared types and constants for the sustained fault supervisor
// Holds reset values of the registers, timing constants and the cause codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned BytesW  = 24;
  localparam int unsigned StreakW = 8;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [TimeW-1:0]   ArmSettleMs     = 32'd15000;
  localparam logic [TimeW-1:0]   StreakForgiveMs = 32'd600000;
  localparam logic [StreakW-1:0] DegradeStreak   = 8'd2;
  localparam logic [StreakW-1:0] StreakMax       = 8'hFF;

  localparam logic [BytesW-1:0] HeapFloorRst    = 24'd12288;
  localparam logic [BytesW-1:0] FragFloorRst    = 24'd20480;
  localparam logic [TimeW-1:0]  HeapGraceRst    = 32'd15000;
  localparam logic [TimeW-1:0]  FragGraceRst    = 32'd120000;
  localparam logic [TimeW-1:0]  LinkGraceRst    = 32'd120000;
  localparam logic [TimeW-1:0]  StallGraceRst   = 32'd30000;
  localparam logic [TimeW-1:0]  ArmFallbackRst  = 32'd60000;
  localparam logic [BytesW-1:0] LowWaterRst     = '1;

  typedef enum logic [2:0] {
    CAUSE_NIL   = 3'd0,
    CAUSE_HEAP  = 3'd1,
    CAUSE_FRAG  = 3'd2,
    CAUSE_LINK  = 3'd3,
    CAUSE_STALL = 3'd4
  } cause_e;

  typedef enum logic [2:0] {
    REG_HEAP_FLOOR   = 3'd0,
    REG_FRAG_FLOOR   = 3'd1,
    REG_HEAP_GRACE   = 3'd2,
    REG_FRAG_GRACE   = 3'd3,
    REG_LINK_GRACE   = 3'd4,
    REG_STALL_GRACE  = 3'd5,
    REG_ARM_FALLBACK = 3'd6,
    REG_STANDALONE   = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

// ===== hdl/sustained_fault_supervisor.sv =====
// ----------------------------------------------------------------------------
// sustained_fault_supervisor: health supervisor with grace-timed faults
// Watches heap, fragmentation, link and heartbeat per sample tick and orders
// a restart once a fault has lasted for its grace time.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid_i / in_ready_o) carries one sample tick per
//   transaction. Output channel (out_valid_o / out_ready_i) returns exactly
//   one result per tick, in order.
//   Path: a tick is registered in the input register, evaluated against the
//   supervisor state from that register, and its result is then held in the
//   output register.
//   Throughput: one tick per cycle while out_ready_i is high; a state update
//   is one pass of compares and subtracts; the next tick follows behind.
//   Stall: when the receiver holds out_ready_i low the output register keeps
//   its result, the input register fills and in_ready_o drops; nothing is
//   lost or repeated.
//   Reset: rst_ni clears all timers, the streak, the degraded latch and sets
//   the low-water mark to all ones; the registers return to their defaults.
//   Configuration: APB writes, register i at byte address 4*i, only while
//   the block is idle. pready is always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sustained_fault_supervisor (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // configuration
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [sfs_pkg::AddrW-1:0]    paddr,
  input  wire logic [sfs_pkg::DataW-1:0]    pwdata,
  output logic      [sfs_pkg::DataW-1:0]    prdata,
  output logic                              pready,
  // tick input
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [sfs_pkg::TimeW-1:0]    now_ms_i,
  input  wire logic [sfs_pkg::BytesW-1:0]   free_heap_i,
  input  wire logic [sfs_pkg::BytesW-1:0]   largest_block_i,
  input  wire logic                         link_up_i,
  input  wire logic [sfs_pkg::TimeW-1:0]    heartbeat_i,
  input  wire logic                         listeners_ready_i,
  // result output
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic                              restart_o,
  output logic      [2:0]                   cause_o,
  output logic      [sfs_pkg::StreakW-1:0]  streak_o,
  output logic                              degraded_o,
  output logic      [sfs_pkg::BytesW-1:0]   min_largest_o,
  output logic                              armed_o
);
  import sfs_pkg::*;

  // configuration registers
  logic [BytesW-1:0] heap_floor_q, frag_floor_q;
  logic [TimeW-1:0]  heap_grace_q, frag_grace_q, link_grace_q;
  logic [TimeW-1:0]  stall_grace_q, arm_fallback_q;
  logic              standalone_q;

  logic     cfg_wr;
  reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_floor_q   <= HeapFloorRst;
      frag_floor_q   <= FragFloorRst;
      heap_grace_q   <= HeapGraceRst;
      frag_grace_q   <= FragGraceRst;
      link_grace_q   <= LinkGraceRst;
      stall_grace_q  <= StallGraceRst;
      arm_fallback_q <= ArmFallbackRst;
      standalone_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_HEAP_FLOOR:   heap_floor_q   <= pwdata[BytesW-1:0];
        REG_FRAG_FLOOR:   frag_floor_q   <= pwdata[BytesW-1:0];
        REG_HEAP_GRACE:   heap_grace_q   <= pwdata;
        REG_FRAG_GRACE:   frag_grace_q   <= pwdata;
        REG_LINK_GRACE:   link_grace_q   <= pwdata;
        REG_STALL_GRACE:  stall_grace_q  <= pwdata;
        REG_ARM_FALLBACK: arm_fallback_q <= pwdata;
        REG_STANDALONE:   standalone_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_HEAP_FLOOR:   prdata = {{(DataW-BytesW){1'b0}}, heap_floor_q};
      REG_FRAG_FLOOR:   prdata = {{(DataW-BytesW){1'b0}}, frag_floor_q};
      REG_HEAP_GRACE:   prdata = heap_grace_q;
      REG_FRAG_GRACE:   prdata = frag_grace_q;
      REG_LINK_GRACE:   prdata = link_grace_q;
      REG_STALL_GRACE:  prdata = stall_grace_q;
      REG_ARM_FALLBACK: prdata = arm_fallback_q;
      REG_STANDALONE:   prdata = {{(DataW-1){1'b0}}, standalone_q};
      default:          prdata = '0;
    endcase
  end

  // handshake and pipeline control
  logic s1_valid_q;
  logic advance;

  assign advance    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  // input register
  logic [TimeW-1:0]  now_q, beat_q;
  logic [BytesW-1:0] heap_q, largest_q;
  logic              link_q, lsn_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      now_q       <= now_ms_i;
      heap_q      <= free_heap_i;
      largest_q   <= largest_block_i;
      link_q      <= link_up_i;
      beat_q      <= heartbeat_i;
      lsn_ready_q <= listeners_ready_i;
    end
  end

  // supervisor state
  logic [TimeW-1:0]   heap_since_q, frag_since_q, link_since_q;
  logic [TimeW-1:0]   last_beat_q, beat_change_q, ready_at_q;
  logic [StreakW-1:0] streak_q;
  logic               degraded_q;
  logic [BytesW-1:0]  low_water_q;

  logic [TimeW-1:0]   heap_since_d, frag_since_d, link_since_d;
  logic [TimeW-1:0]   last_beat_d, beat_change_d, ready_at_d;
  logic [StreakW-1:0] streak_d;
  logic               degraded_d;
  logic [BytesW-1:0]  low_water_d;

  logic [BytesW-1:0]  shown_low;
  logic [TimeW-1:0]   lbc, rdy_at, settle_dt, heap_dt, frag_dt, link_dt, stall_dt;
  logic [StreakW-1:0] streak_f;
  logic               armed;
  logic               heap_flt, frag_flt, link_flt;
  logic               heap_trip, frag_trip, link_trip, stall_trip;
  logic               frag_run, link_run;
  cause_e             cause;

  always_comb begin
    shown_low = (largest_q < low_water_q) ? largest_q : low_water_q;
    lbc       = (beat_q != last_beat_q) ? now_q : beat_change_q;
    // a ready tick at time zero records zero, which still reads as not ready
    rdy_at    = (lsn_ready_q && ready_at_q == '0) ? now_q : ready_at_q;
    streak_f  = (streak_q != '0 && now_q >= StreakForgiveMs) ? '0 : streak_q;

    settle_dt = now_q - rdy_at;
    armed     = (now_q >= arm_fallback_q) ||
                (rdy_at != '0 && settle_dt >= ArmSettleMs);

    heap_flt  = heap_q < heap_floor_q;
    frag_flt  = largest_q < frag_floor_q;
    link_flt  = !link_q;

    heap_dt   = now_q - heap_since_q;
    frag_dt   = now_q - frag_since_q;
    link_dt   = now_q - link_since_q;
    stall_dt  = now_q - lbc;

    heap_trip  = armed && heap_flt && heap_since_q != '0 && heap_dt >= heap_grace_q;
    frag_run   = armed && !heap_trip;
    frag_trip  = frag_run && frag_flt && frag_since_q != '0 && frag_dt >= frag_grace_q;
    link_run   = frag_run && !frag_trip && !standalone_q;
    link_trip  = link_run && link_flt && link_since_q != '0 && link_dt >= link_grace_q;
    stall_trip = frag_run && !frag_trip && !link_trip && stall_dt >= stall_grace_q;

    if (heap_trip)       cause = CAUSE_HEAP;
    else if (frag_trip)  cause = CAUSE_FRAG;
    else if (link_trip)  cause = CAUSE_LINK;
    else if (stall_trip) cause = CAUSE_STALL;
    else                 cause = CAUSE_NIL;

    // the heap, frag and link timers only move for checks that actually ran
    heap_since_d = heap_since_q;
    frag_since_d = frag_since_q;
    link_since_d = link_since_q;
    if (armed) begin
      heap_since_d = !heap_flt ? '0 : ((heap_since_q == '0) ? now_q : heap_since_q);
    end
    if (frag_run) begin
      frag_since_d = !frag_flt ? '0 : ((frag_since_q == '0) ? now_q : frag_since_q);
    end
    if (link_run) begin
      link_since_d = !link_flt ? '0 : ((link_since_q == '0) ? now_q : link_since_q);
    end
    last_beat_d   = beat_q;
    beat_change_d = lbc;
    ready_at_d    = rdy_at;
    low_water_d   = shown_low;
    streak_d      = streak_f;
    degraded_d    = degraded_q;

    if (cause != CAUSE_NIL) begin
      streak_d      = (streak_f == StreakMax) ? streak_f : streak_f + 1'b1;
      degraded_d    = streak_d >= DegradeStreak;
      heap_since_d  = '0;
      frag_since_d  = '0;
      link_since_d  = '0;
      last_beat_d   = '0;
      beat_change_d = '0;
      ready_at_d    = '0;
      low_water_d   = LowWaterRst;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_since_q  <= '0;
      frag_since_q  <= '0;
      link_since_q  <= '0;
      last_beat_q   <= '0;
      beat_change_q <= '0;
      ready_at_q    <= '0;
      streak_q      <= '0;
      degraded_q    <= 1'b0;
      low_water_q   <= LowWaterRst;
    end else if (advance) begin
      heap_since_q  <= heap_since_d;
      frag_since_q  <= frag_since_d;
      link_since_q  <= link_since_d;
      last_beat_q   <= last_beat_d;
      beat_change_q <= beat_change_d;
      ready_at_q    <= ready_at_d;
      streak_q      <= streak_d;
      degraded_q    <= degraded_d;
      low_water_q   <= low_water_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || out_ready_i) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      restart_o     <= cause != CAUSE_NIL;
      cause_o       <= cause;
      streak_o      <= streak_d;
      degraded_o    <= degraded_d;
      min_largest_o <= shown_low;
      armed_o       <= armed;
    end
  end

  // checks
  a_restart_armed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && restart_o |-> armed_o && streak_o != '0)
    else $error("restart ordered while not armed or with zero streak");

  a_restart_degraded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && restart_o |-> degraded_o == (streak_o >= DegradeStreak))
    else $error("degraded latch disagrees with streak at restart");

  a_restart_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cause != CAUSE_NIL |=> low_water_q == LowWaterRst && ready_at_q == '0)
    else $error("timers not cleared after restart");

endmodule

`default_nettype wire

// ===== sim/tb_sustained_fault_supervisor.sv =====
// ----------------------------------------------------------------------------
// tb_sustained_fault_supervisor: self-checking bench for the fault supervisor
// Feeds sample ticks through the valid/ready input and reprograms the APB
// registers between phases. A scoreboard mirrors the grace timers, arming,
// streak and low-water mark, and checks every result field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sustained_fault_supervisor;
  import sfs_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam logic [BytesW-1:0] BytesMax = '1;

  typedef struct {
    logic [TimeW-1:0]  now_ms;
    logic [BytesW-1:0] free_heap;
    logic [BytesW-1:0] largest_block;
    logic              link_up;
    logic [TimeW-1:0]  heartbeat;
    logic              listeners_ready;
  } tick_t;

  typedef struct {
    logic               restart;
    logic [2:0]         cause;
    logic [StreakW-1:0] streak;
    logic               degraded;
    logic [BytesW-1:0]  min_largest;
    logic               armed;
  } verdict_t;

  class fault_scoreboard;
    logic [BytesW-1:0]  heap_floor, frag_floor;
    logic [TimeW-1:0]   heap_grace, frag_grace, link_grace, stall_grace, arm_fallback;
    logic               standalone;
    logic [TimeW-1:0]   heap_low_since, frag_low_since, link_down_since;
    logic [TimeW-1:0]   last_beat, last_beat_change, ready_at;
    logic [StreakW-1:0] streak;
    logic               degraded;
    logic [BytesW-1:0]  low_water;
    verdict_t           verdict_q[$];
    bit                 last_restart;
    int unsigned        failures, checked, peak_streak, degraded_hits;
    int unsigned        by_cause[5];

    function new();
      heap_floor   = HeapFloorRst;
      frag_floor   = FragFloorRst;
      heap_grace   = HeapGraceRst;
      frag_grace   = FragGraceRst;
      link_grace   = LinkGraceRst;
      stall_grace  = StallGraceRst;
      arm_fallback = ArmFallbackRst;
      standalone   = 1'b0;
      clear_timers();
      streak       = '0;
      degraded     = 1'b0;
      last_restart = 1'b0;
    endfunction

    function void clear_timers();
      heap_low_since   = '0;
      frag_low_since   = '0;
      link_down_since  = '0;
      last_beat        = '0;
      last_beat_change = '0;
      ready_at         = '0;
      low_water        = LowWaterRst;
    endfunction

    function void set_reg(reg_idx_e idx, logic [DataW-1:0] value);
      case (idx)
        REG_HEAP_FLOOR:   heap_floor   = value[BytesW-1:0];
        REG_FRAG_FLOOR:   frag_floor   = value[BytesW-1:0];
        REG_HEAP_GRACE:   heap_grace   = value;
        REG_FRAG_GRACE:   frag_grace   = value;
        REG_LINK_GRACE:   link_grace   = value;
        REG_STALL_GRACE:  stall_grace  = value;
        REG_ARM_FALLBACK: arm_fallback = value;
        REG_STANDALONE:   standalone   = value[0];
        default: ;
      endcase
    endfunction

    // zero in the timestamp means the fault is not currently seen
    function bit sustained(input bit fault, inout logic [TimeW-1:0] since,
                           input logic [TimeW-1:0] now, input logic [TimeW-1:0] grace);
      logic [TimeW-1:0] held_for;
      if (!fault) begin
        since = '0;
        return 1'b0;
      end
      if (since == '0) begin
        since = now;
        return 1'b0;
      end
      held_for = now - since;
      return held_for >= grace;
    endfunction

    function void note_tick(tick_t t);
      verdict_t          v;
      cause_e            why;
      logic [TimeW-1:0]  now, since_ready, since_beat;
      logic [BytesW-1:0] shown;
      logic              armed_now;
      why = CAUSE_NIL;
      now = t.now_ms;
      if (t.largest_block < low_water) low_water = t.largest_block;
      shown = low_water;
      if (t.heartbeat != last_beat) begin
        last_beat = t.heartbeat;
        last_beat_change = now;
      end
      if (t.listeners_ready && ready_at == '0) ready_at = now;
      if (streak != '0 && now >= StreakForgiveMs) streak = '0;
      since_ready = now - ready_at;
      armed_now = (now >= arm_fallback) || (ready_at != '0 && since_ready >= ArmSettleMs);
      if (armed_now) begin
        since_beat = now - last_beat_change;
        if (sustained(t.free_heap < heap_floor, heap_low_since, now, heap_grace)) begin
          why = CAUSE_HEAP;
        end else if (sustained(t.largest_block < frag_floor, frag_low_since, now,
                               frag_grace)) begin
          why = CAUSE_FRAG;
        end else if (!standalone && sustained(!t.link_up, link_down_since, now,
                                              link_grace)) begin
          why = CAUSE_LINK;
        end else if (since_beat >= stall_grace) begin
          why = CAUSE_STALL;
        end
      end
      if (why != CAUSE_NIL) begin
        if (streak != StreakMax) streak = streak + 1'b1;
        degraded = (streak >= DegradeStreak);
        clear_timers();
        by_cause[int'(why)]++;
      end
      if (32'(streak) > peak_streak) peak_streak = 32'(streak);
      if (degraded) degraded_hits++;
      v.restart     = (why != CAUSE_NIL);
      v.cause       = why;
      v.streak      = streak;
      v.degraded    = degraded;
      v.min_largest = shown;
      v.armed       = armed_now;
      last_restart  = v.restart;
      verdict_q.push_back(v);
    endfunction

    function void report_field(string field, logic [31:0] want, logic [31:0] got);
      failures++;
      $display("[%0t] %s mismatch: expected %0h, actual %0h", $time, field, want, got);
    endfunction

    function void check_result(verdict_t got);
      verdict_t want;
      checked++;
      if (verdict_q.size() == 0) begin
        failures++;
        $display("[%0t] result with no tick outstanding: expected none, actual cause %0d",
                 $time, got.cause);
        return;
      end
      want = verdict_q.pop_front();
      if (got.restart !== want.restart)
        report_field("restart", 32'(want.restart), 32'(got.restart));
      if (got.cause !== want.cause) report_field("cause", 32'(want.cause), 32'(got.cause));
      if (got.streak !== want.streak)
        report_field("streak", 32'(want.streak), 32'(got.streak));
      if (got.degraded !== want.degraded)
        report_field("degraded", 32'(want.degraded), 32'(got.degraded));
      if (got.min_largest !== want.min_largest)
        report_field("min_largest", 32'(want.min_largest), 32'(got.min_largest));
      if (got.armed !== want.armed) report_field("armed", 32'(want.armed), 32'(got.armed));
    endfunction

    function int unsigned outstanding();
      return verdict_q.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [AddrW-1:0]    paddr = '0;
  logic [DataW-1:0]    pwdata = '0;
  logic [DataW-1:0]    prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [TimeW-1:0]    now_ms_i = '0;
  logic [BytesW-1:0]   free_heap_i = '0;
  logic [BytesW-1:0]   largest_block_i = '0;
  logic                link_up_i = 1'b0;
  logic [TimeW-1:0]    heartbeat_i = '0;
  logic                listeners_ready_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                restart_o;
  logic [2:0]          cause_o;
  logic [StreakW-1:0]  streak_o;
  logic                degraded_o;
  logic [BytesW-1:0]   min_largest_o;
  logic                armed_o;

  fault_scoreboard sb;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned idle_mode = 0;
  int unsigned sent = 0;
  int unsigned quiet_cycles = 0;

  // uptime scenario that the random ticks follow
  logic [TimeW-1:0] up = '0;
  logic [TimeW-1:0] beat = '0;
  bit heap_bad, frag_bad, link_down, stalled, ready_seen;

  sustained_fault_supervisor DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .now_ms_i         (now_ms_i),
    .free_heap_i      (free_heap_i),
    .largest_block_i  (largest_block_i),
    .link_up_i        (link_up_i),
    .heartbeat_i      (heartbeat_i),
    .listeners_ready_i(listeners_ready_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .restart_o        (restart_o),
    .cause_o          (cause_o),
    .streak_o         (streak_o),
    .degraded_o       (degraded_o),
    .min_largest_o    (min_largest_o),
    .armed_o          (armed_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : collect
    verdict_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.restart     = restart_o;
      got.cause       = cause_o;
      got.streak      = streak_o;
      got.degraded    = degraded_o;
      got.min_largest = min_largest_o;
      got.armed       = armed_o;
      sb.check_result(got);
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("[%0t] no transaction for %0d cycles", $time, StallLimit);
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [BytesW-1:0] pick_bytes(logic [BytesW-1:0] threshold, bit below);
    if (below) begin
      if (threshold == '0) return '0;
      if ($urandom_range(7) == 0) return threshold - 1'b1;
      return BytesW'($urandom_range(threshold - 1, 0));
    end
    if ($urandom_range(7) == 0) return threshold;
    return BytesW'($urandom_range(BytesMax, threshold));
  endfunction

  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    now_ms_i          <= t.now_ms;
    free_heap_i       <= t.free_heap;
    largest_block_i   <= t.largest_block;
    link_up_i         <= t.link_up;
    heartbeat_i       <= t.heartbeat;
    listeners_ready_i <= t.listeners_ready;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_tick(t);
    sent++;
    // rotate through the idling patterns so gaps hit every pipeline phase
    if (sent % 20 == 0) begin
      idle_mode = (idle_mode + 1) % 4;
      idle_pct  = (idle_mode == 1) ? 58 : (idle_mode == 3) ? 12 : 0;
      stall_pct = (idle_mode == 2) ? 58 : (idle_mode == 3) ? 12 : 0;
    end
  endtask

  task automatic send_fields(input logic [TimeW-1:0] now, input logic [BytesW-1:0] heap,
                             input logic [BytesW-1:0] largest, input logic link,
                             input logic [TimeW-1:0] hb, input logic ready);
    tick_t t;
    t.now_ms          = now;
    t.free_heap       = heap;
    t.largest_block   = largest;
    t.link_up         = link;
    t.heartbeat       = hb;
    t.listeners_ready = ready;
    send_tick(t);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [DataW-1:0] heap_floor, input logic [DataW-1:0] frag_floor,
                           input logic [DataW-1:0] heap_grace, input logic [DataW-1:0] frag_grace,
                           input logic [DataW-1:0] link_grace, input logic [DataW-1:0] stall_grace,
                           input logic [DataW-1:0] arm_fallback, input logic [DataW-1:0] alone);
    write_reg(REG_HEAP_FLOOR, heap_floor);
    write_reg(REG_FRAG_FLOOR, frag_floor);
    write_reg(REG_HEAP_GRACE, heap_grace);
    write_reg(REG_FRAG_GRACE, frag_grace);
    write_reg(REG_LINK_GRACE, link_grace);
    write_reg(REG_STALL_GRACE, stall_grace);
    write_reg(REG_ARM_FALLBACK, arm_fallback);
    write_reg(REG_STANDALONE, alone);
  endtask

  // stop feeding and let every outstanding result drain
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned count, input int unsigned max_step,
                           input bit saturate);
    tick_t t;
    repeat (count) begin
      if (saturate || $urandom_range(29) == 0) begin
        t.now_ms          = $urandom;
        t.free_heap       = BytesW'($urandom);
        t.largest_block   = BytesW'($urandom);
        t.link_up         = 1'($urandom);
        t.heartbeat       = $urandom;
        t.listeners_ready = 1'($urandom);
        // keep below the forgiveness point so the streak can climb
        if (saturate) t.now_ms = $urandom_range(StreakForgiveMs - 1, 1);
      end else begin
        if (sb.last_restart) begin
          case ($urandom_range(7))
            0:       up = '0;
            1:       up = StreakForgiveMs - $urandom_range(3000);
            2:       up = '1 - $urandom_range(3000);
            default: up = $urandom_range(3000, 1);
          endcase
          heap_bad   = 1'b0;
          frag_bad   = 1'b0;
          link_down  = 1'b0;
          stalled    = 1'b0;
          ready_seen = 1'b0;
          beat       = $urandom_range(3);
        end
        up = up + $urandom_range(max_step);
        if ($urandom_range(11) == 0) heap_bad = !heap_bad;
        if ($urandom_range(11) == 0) frag_bad = !frag_bad;
        if ($urandom_range(11) == 0) link_down = !link_down;
        if ($urandom_range(11) == 0) stalled = !stalled;
        if (!stalled) beat = beat + $urandom_range(3, 1);
        if (!ready_seen && $urandom_range(15) == 0) ready_seen = 1'b1;
        t.now_ms          = up;
        t.free_heap       = pick_bytes(sb.heap_floor, heap_bad);
        t.largest_block   = pick_bytes(sb.frag_floor, frag_bad);
        t.link_up         = !link_down;
        t.heartbeat       = beat;
        t.listeners_ready = ready_seen;
      end
      send_tick(t);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // reset configuration: one restart of each cause, then forgiveness
    send_fields(32'd0, BytesMax, BytesMax, 1'b1, 32'd0, 1'b1);   // ready at time zero
    send_fields(32'd1000, '0, BytesMax, 1'b0, 32'd1, 1'b1);      // faults while unarmed
    send_fields(32'd16000, BytesMax, BytesMax, 1'b1, 32'd2, 1'b0);
    send_fields(32'd17000, '0, '0, 1'b1, 32'd3, 1'b0);           // heap and frag seen together
    send_fields(32'd32000, '0, '0, 1'b1, 32'd4, 1'b0);           // heap trips
    send_fields(32'd33000, BytesMax, 24'd1000, 1'b0, 32'd5, 1'b0);
    send_fields(32'd60000, BytesMax, 24'd1000, 1'b0, 32'd5, 1'b0);
    send_fields(32'd180000, BytesMax, 24'd1000, 1'b0, 32'd6, 1'b0);
    send_fields(32'd200000, BytesMax, BytesMax, 1'b0, 32'd7, 1'b1);
    send_fields(32'd320000, BytesMax, BytesMax, 1'b0, 32'd8, 1'b1);
    send_fields(32'd400000, BytesMax, BytesMax, 1'b1, 32'd9, 1'b0);
    send_fields(32'd430000, BytesMax, BytesMax, 1'b1, 32'd9, 1'b0);
    send_fields(32'd600000, BytesMax, BytesMax, 1'b1, 32'd10, 1'b0);
    send_fields('1, BytesMax, BytesMax, 1'b1, '1, 1'b1);
    send_fields(32'd500, 24'd100, BytesMax, 1'b1, '0, 1'b1);     // after the wrap
    send_fields(32'd700, 24'd12287, 24'd20479, 1'b0, '0, 1'b1);
    send_fields(32'd900, 24'd12288, 24'd20480, 1'b1, 32'd1, 1'b0);
    settle();

    configure(32'd4096, 32'd8192, 32'd1500, 32'd2500, 32'd3000, 32'd2000, 32'd6000, 32'd0);
    run_phase(60, 700, 1'b0);
    settle();

    // floors at the top, zero grace, link check off; upper data bits are dropped
    configure('1, 32'hFF00_0000 | BytesMax, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
    run_phase(30, 300, 1'b0);
    settle();

    // zero stall grace trips every tick, so the streak runs into saturation
    configure('0, '0, '0, '0, '0, '0, '0, 32'd1);
    run_phase(265, 0, 1'b1);
    settle();

    configure('0, '0, '1, '1, '1, '1, '1, 32'd0);
    run_phase(25, 2000, 1'b0);
    settle();

    configure($urandom, $urandom, $urandom_range(4000), $urandom_range(4000),
              $urandom_range(4000), $urandom_range(4000), $urandom_range(10000),
              $urandom_range(1));
    run_phase(30, 1500, 1'b0);
    settle();

    configure(HeapFloorRst, FragFloorRst, HeapGraceRst, FragGraceRst, LinkGraceRst,
              StallGraceRst, ArmFallbackRst, 32'd0);
    run_phase(30, 20000, 1'b0);
    settle();
    repeat (8) @(posedge clk_i);

    $display("summary: %0d ticks checked; restarts heap %0d, frag %0d, link %0d, stall %0d",
             sb.checked, sb.by_cause[CAUSE_HEAP], sb.by_cause[CAUSE_FRAG],
             sb.by_cause[CAUSE_LINK], sb.by_cause[CAUSE_STALL]);
    $display("summary: peak streak %0d, %0d ticks in degraded mode, %0d mismatches",
             sb.peak_streak, sb.degraded_hits, sb.failures);
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
